>>> rtl/core/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg: shared types and constants of the decimal lexicographic sorter
// Widths, key format and the front-to-back queue word.
// ----------------------------------------------------------------------------
package dls_pkg;

    localparam int MAX_ITEMS  = 16;
    localparam int VAL_W      = 31;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int MAX_DIGITS = 10;
    localparam int DIG_W      = 4;
    localparam int LEN_W      = 4;
    // key: digits left-aligned (padded with 0), no length field; padding with a
    // digit below 0 is emulated by comparing digits as d+1 with pad 0
    localparam int KEY_W      = MAX_DIGITS * DIG_W;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [KEY_W-1:0] t_key;

    // one classified word handed from the front to the back
    typedef struct packed {
        t_val value;
        t_key key;
        logic last;
    } t_qword;

    localparam int QW_W = $bits(t_qword);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT
    } t_bstate;

    // digit order key: each digit stored as digit+1, unused slots 0, so a
    // prefix (padded with 0) sorts below any longer string
    function automatic logic key_gt(input t_key a, input t_key b);
        return a > b;
    endfunction

endpackage

>>> rtl/core/dls_if.sv
// ----------------------------------------------------------------------------
// dls_in_if / dls_out_if: valid/ready channels of the sorter
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface dls_in_if;
    logic                      valid;
    logic                      ready;
    logic [dls_pkg::VAL_W-1:0] value;
    logic                      last;
    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface dls_out_if;
    logic                      valid;
    logic                      ready;
    logic [dls_pkg::VAL_W-1:0] sorted_value;
    logic                      final_res;
    logic                      dropped;
    modport source (output valid, output sorted_value, output final_res,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input dropped, output ready);
endinterface

>>> rtl/core/dls_front.sv
// ----------------------------------------------------------------------------
// dls_front: decimal digit extraction
// Peels one decimal digit per cycle (multiply by reciprocal) and builds the
// left-aligned digit key, then hands the word to the queue.
// ----------------------------------------------------------------------------
module dls_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dls_in_if.sink                     in_ch,
    output logic                       o_q_valid,
    input  logic                       i_q_ready,
    output logic [dls_pkg::QW_W-1:0]   o_q_word
);
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    dls_pkg::t_val         r_value;
    dls_pkg::t_val         r_rem, n_rem;
    logic                  r_last;
    dls_pkg::t_key         r_key, n_key;
    logic [dls_pkg::VAL_W-1:0] quo;
    logic [dls_pkg::DIG_W-1:0] dig;
    logic [63:0]           prod;
    dls_pkg::t_qword       qw;

    // v/10 via reciprocal 0xCCCCCCCD >> 35, exact for 32-bit v
    assign prod = {33'd0, r_rem} * 64'h0000_0000_CCCC_CCCD;
    assign quo  = dls_pkg::VAL_W'(prod[63:35]);
    assign dig  = dls_pkg::DIG_W'(r_rem - dls_pkg::VAL_W'(quo * 31'd10));

    assign in_ch.ready = !r_busy;

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_rem  = r_rem;
        n_key  = r_key;
        if (in_ch.valid && in_ch.ready) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_rem  = in_ch.value;
            n_key  = '0;
        end else if (r_busy && !r_done) begin
            // shift new digit in at the top; key realigned as digits arrive
            n_key  = {dls_pkg::DIG_W'(dig + 4'd1),
                      r_key[dls_pkg::KEY_W-1:dls_pkg::DIG_W]};
            n_rem  = quo;
            n_done = (quo == '0);
        end else if (r_busy && r_done && i_q_ready) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_key <= n_key;
        if (in_ch.valid && in_ch.ready) begin
            r_value <= in_ch.value;
            r_last  <= in_ch.last;
        end
    end

    // key holds most significant digit in the top slot of the filled run;
    // the run sits at the top once all digits are shifted in (MSB last in)
    assign qw.value = r_value;
    assign qw.key   = r_key;
    assign qw.last  = r_last;
    assign o_q_valid = r_busy && r_done;
    assign o_q_word  = qw;
endmodule

>>> rtl/core/dls_queue.sv
// ----------------------------------------------------------------------------
// dls_queue: two-entry FIFO between front and back
// ----------------------------------------------------------------------------
module dls_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_valid,
    output logic                     o_wr_ready,
    input  logic [dls_pkg::QW_W-1:0] i_wr_word,
    output logic                     o_rd_valid,
    input  logic                     i_rd_ready,
    output logic [dls_pkg::QW_W-1:0] o_rd_word
);
    logic [dls_pkg::QW_W-1:0] r_mem [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic                     wr, rd;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_word  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_wr_word;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");
endmodule

>>> rtl/core/dls_back.sv
// ----------------------------------------------------------------------------
// dls_back: sorted insertion store and emitter
// A register row kept in descending key order; each word is inserted by
// parallel compare and shift. On last, entries stream out.
// ----------------------------------------------------------------------------
module dls_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_ready,
    input  logic [dls_pkg::QW_W-1:0] i_q_word,
    dls_out_if.source                out_ch
);
    dls_pkg::t_bstate          r_state, n_state;
    dls_pkg::t_val             r_val [dls_pkg::MAX_ITEMS];
    dls_pkg::t_key             r_key [dls_pkg::MAX_ITEMS];
    logic [dls_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [dls_pkg::CNT_W-1:0] r_oidx, n_oidx;
    logic                      r_ovf, n_ovf;
    logic                      r_ovalid, n_ovalid;
    dls_pkg::t_val             r_oval;
    logic                      r_ofin, r_odrop;
    dls_pkg::t_qword           qw;
    logic [dls_pkg::MAX_ITEMS-1:0] gt;
    logic                      take, ins, load_out;

    assign qw = dls_pkg::t_qword'(i_q_word);
    assign o_q_ready = (r_state == dls_pkg::ST_LOAD);
    assign take = i_q_valid && o_q_ready;
    assign ins  = take && (r_cnt < dls_pkg::CNT_W'(dls_pkg::MAX_ITEMS));

    // new word goes ahead of entry k when it orders above it
    always_comb begin
        for (int k = 0; k < dls_pkg::MAX_ITEMS; k++)
            gt[k] = (dls_pkg::CNT_W'(k) < r_cnt) ? dls_pkg::key_gt(qw.key, r_key[k]) : 1'b1;
    end

    assign load_out = !r_ovalid || out_ch.ready;

    // control
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_oidx   = r_oidx;
        n_ovalid = r_ovalid;
        if (r_ovalid && out_ch.ready) n_ovalid = 1'b0;
        case (r_state)
            dls_pkg::ST_LOAD: begin
                if (take) begin
                    if (ins) n_cnt = r_cnt + 1'b1;
                    else     n_ovf = 1'b1;
                    if (qw.last) begin
                        n_state = dls_pkg::ST_EMIT;
                        n_oidx  = '0;
                    end
                end
            end
            dls_pkg::ST_EMIT: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_oidx   = r_oidx + 1'b1;
                    if (r_oidx + 1'b1 == r_cnt) begin
                        n_state = dls_pkg::ST_LOAD;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: n_state = dls_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dls_pkg::ST_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
        end
    end

    // insertion shift of the row
    always_ff @(posedge i_clk) begin
        if (ins) begin
            for (int k = 0; k < dls_pkg::MAX_ITEMS; k++) begin
                if (gt[k]) begin
                    if (k == 0 || !gt[k-1]) begin
                        r_val[k] <= qw.value;
                        r_key[k] <= qw.key;
                    end else begin
                        r_val[k] <= r_val[k-1];
                        r_key[k] <= r_key[k-1];
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == dls_pkg::ST_EMIT && load_out) begin
            r_oval  <= r_val[r_oidx[dls_pkg::IDX_W-1:0]];
            r_ofin  <= (r_oidx + 1'b1 == r_cnt);
            r_odrop <= r_ovf;
        end
    end

    assign out_ch.valid        = r_ovalid;
    assign out_ch.sorted_value = r_oval;
    assign out_ch.final_res    = r_ofin;
    assign out_ch.dropped      = r_odrop;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dls_pkg::CNT_W'(dls_pkg::MAX_ITEMS))
        else $error("count beyond store");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dls_pkg::ST_EMIT |-> r_oidx < r_cnt)
        else $error("emit index past count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && qw.last |=> r_state == dls_pkg::ST_EMIT)
        else $error("last did not start emit");
endmodule

>>> rtl/core/decimal_lexicographic_sorter.sv
// Per word: digit extraction in the front (one digit a cycle), then an
//   insert into the sorted row; results stream out after the last word.
// Flow: the front takes no new word until the current one is extracted and
//   queued; results stream one per cycle from the sorted register row while out_ch.ready is high.
// Reset: synchronous active-low i_rst_n clears count, flags and all handshakes.
// ----------------------------------------------------------------------------
// decimal_lexicographic_sorter: top level
// Front digit extractor, queue, and sorted insertion back end.
// ----------------------------------------------------------------------------
module decimal_lexicographic_sorter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dls_in_if.sink    in_ch,
    dls_out_if.source out_ch
);
    logic                     f_valid, f_ready, b_valid, b_ready;
    logic [dls_pkg::QW_W-1:0] f_word, b_word;

    dls_front u_front (.i_clk, .i_rst_n, .in_ch,
        .o_q_valid(f_valid), .i_q_ready(f_ready), .o_q_word(f_word));
    dls_queue u_queue (.i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_word(f_word),
        .o_rd_valid(b_valid), .i_rd_ready(b_ready), .o_rd_word(b_word));
    dls_back u_back (.i_clk, .i_rst_n,
        .i_q_valid(b_valid), .o_q_ready(b_ready), .i_q_word(b_word), .out_ch);
endmodule

>>> bench/dls_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_tb_if: bench-side note on the sorter channels
// The channel interfaces come from the RTL; this file only holds a helper
// package for the bench's ordering rule.
// ----------------------------------------------------------------------------
package dls_tb_pkg;

    // digit count of a value, zero counts as one digit
    function automatic int dec_len(input logic [30:0] v);
        int n;
        n = 0;
        do begin
            n++;
            v = v / 10;
        end while (v != 0);
        return n;
    endfunction

    // true if a sorts strictly ahead of b in descending digit-string order
    function automatic bit str_ahead(input logic [30:0] a, input logic [30:0] b);
        int la;
        int lb;
        int m;
        int i;
        logic [30:0] pa;
        logic [30:0] pb;
        int da;
        int db;
        la = dec_len(a);
        lb = dec_len(b);
        m = (la < lb) ? la : lb;
        for (i = 0; i < m; i++) begin
            pa = a;
            pb = b;
            repeat (la - 1 - i) pa = pa / 10;
            repeat (lb - 1 - i) pb = pb / 10;
            da = pa % 10;
            db = pb % 10;
            if (da != db) return da > db;
        end
        return la > lb;
    endfunction

endpackage

>>> bench/dls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_checker: result predictor and scoreboard of the sorter
// Collects each accepted batch, sorts it by decimal string and compares
// every result word against the oldest expected word.
// ----------------------------------------------------------------------------
module dls_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dls_in_if.sink    in_mon,
    dls_out_if.sink   out_mon,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    typedef struct {
        logic [30:0] value;
        logic        fin;
        logic        drop;
    } t_sorted;

    logic [30:0] batch_q[$];
    bit          batch_drop;
    t_sorted     sorted_q[$];

    task automatic report(input string what);
        o_errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // sort the batch and queue its results
    task automatic sort_batch();
        logic [30:0] row[$];
        logic [30:0] key;
        t_sorted w;
        int j;
        row = batch_q;
        for (int i = 1; i < row.size(); i++) begin
            key = row[i];
            j = i;
            while (j > 0 && dls_tb_pkg::str_ahead(key, row[j-1])) begin
                row[j] = row[j-1];
                j--;
            end
            row[j] = key;
        end
        foreach (row[k]) begin
            w.value = row[k];
            w.fin   = (k == row.size() - 1);
            w.drop  = batch_drop;
            sorted_q.push_back(w);
        end
        batch_q.delete();
        batch_drop = 0;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
        batch_drop = 0;
    end

    always @(posedge i_clk) begin
        t_sorted w;
        if (i_rst_n) begin
            // input side
            if (in_mon.valid && in_mon.ready) begin
                if (batch_q.size() < dls_pkg::MAX_ITEMS) batch_q.push_back(in_mon.value);
                else batch_drop = 1;
                if (in_mon.last) sort_batch();
            end
            // output side
            if (out_mon.valid && out_mon.ready) begin
                o_results++;
                if (sorted_q.size() == 0) begin
                    report($sformatf("unexpected word %0d", out_mon.sorted_value));
                end else begin
                    w = sorted_q.pop_front();
                    if (out_mon.sorted_value !== w.value)
                        report($sformatf("value %0d, want %0d", out_mon.sorted_value, w.value));
                    if (out_mon.final_res !== w.fin)
                        report($sformatf("final %b, want %b", out_mon.final_res, w.fin));
                    if (out_mon.dropped !== w.drop)
                        report($sformatf("dropped %b, want %b", out_mon.dropped, w.drop));
                end
            end
            o_pending = sorted_q.size();
        end
    end
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the sorter bench
// Drives directed and random batches with random gaps and stalls; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    localparam int WATCHDOG = 5000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   results;
    int   idle_cycles;
    int   words_sent;
    int   batches;
    bit   calm;

    dls_in_if  in_ch();
    dls_out_if out_ch();

    decimal_lexicographic_sorter DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    dls_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .in_mon   (in_ch.sink),
        .out_mon  (out_ch.sink),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        out_ch.ready = 0;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(negedge i_clk);
            end
        end
    end

    // send one word, waits for acceptance; valid stays high for the next word
    task automatic send_word(input logic [30:0] v, input logic lst);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // random value spread over digit lengths
    function automatic logic [30:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 31'($urandom_range(0, 9));
            1: return 31'($urandom_range(0, 999));
            2: return 31'($urandom_range(0, 99999));
            3: return 31'($urandom);
            default: return 31'($urandom_range(0, 3) * 10 ** $urandom_range(0, 8)
                                + $urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++)
            send_word(rand_value(), i == n - 1);
        batches++;
    endtask

    initial begin
        int n;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.value = 0;
        in_ch.last = 0;
        idle_cycles = 0;
        words_sent = 0;
        batches = 0;
        calm = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // single zero, single max
        send_word(31'd0, 1'b1);
        send_word(31'h7FFF_FFFF, 1'b1);
        // prefixes, zero and all-ones pattern
        send_word(31'd9, 1'b0);
        send_word(31'd91, 1'b0);
        send_word(31'd0, 1'b0);
        send_word(31'd10, 1'b0);
        send_word(31'd1, 1'b0);
        send_word(31'h7FFF_FFFF, 1'b0);
        send_word(31'd1000000000, 1'b0);
        send_word(31'd99, 1'b0);
        send_word(31'd99, 1'b1);
        // overflow: 18 words, last two dropped
        for (int i = 0; i < 18; i++) send_word(31'(18 - i), i == 17);
        batches += 4;

        // random batches, mostly short, some overfull
        while (words_sent < 160) begin
            if (words_sent > 130) calm = 1;
            case ($urandom_range(0, 5))
                0: n = $urandom_range(17, 20);
                1: n = 16;
                default: n = $urandom_range(1, 8);
            endcase
            send_batch(n);
        end
        in_ch.valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("covered %0d words in %0d batches, %0d results checked",
                 words_sent, batches, results);
        $display("including prefix ties, zero, full and overfull stores");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> decimal_lexicographic_sorter.f
rtl/core/dls_pkg.sv
rtl/core/dls_if.sv
rtl/core/dls_front.sv
rtl/core/dls_queue.sv
rtl/core/dls_back.sv
rtl/core/decimal_lexicographic_sorter.sv
bench/dls_tb_if.sv
bench/dls_checker.sv
bench/tb.sv
